>>> rtl/core/fhc_pkg.sv
// Package for the forwarded header client address parser.
// Holds scanner and sequencer state types, address range constants and the
// character helpers shared by the parser datapath. No dependencies.
package fhc_pkg;

  // Header scanner states.
  typedef enum logic [2:0] {
    SC_BETWEEN,
    SC_KEY,
    SC_BEFORE,
    SC_TOKEN,
    SC_QUOTED
  } scan_t;

  // Capture phase of the current value text.
  typedef enum logic [1:0] {
    PH_NONE,
    PH_PLAIN,
    PH_BRACKET,
    PH_DONE
  } phase_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    C_IDLE,
    C_FETCH,
    C_STEP,
    C_FINISH,
    C_EXPAND,
    C_CHECK,
    C_OUT
  } ctrl_t;

  // Running state of one dotted IPv4 parse.
  typedef struct packed {
    logic        fail;
    logic        saw;
    logic [2:0]  octets;
    logic [7:0]  val;
    logic [31:0] addr;
  } v4_t;

  localparam v4_t V4_INIT = '{fail: 1'b0, saw: 1'b0, octets: 3'd0, val: 8'd0, addr: 32'd0};

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOWER  = 8'h20;

  localparam logic [31:0] NET_10    = 32'h0A000000;
  localparam logic [31:0] NET_172   = 32'hAC100000;
  localparam logic [31:0] NET_192   = 32'hC0A80000;
  localparam logic [31:0] NET_LOOP  = 32'h7F000000;
  localparam logic [31:0] NET_LINK  = 32'hA9FE0000;
  localparam logic [31:0] MASK_8    = 32'hFF000000;
  localparam logic [31:0] MASK_12   = 32'hFFF00000;
  localparam logic [31:0] MASK_16   = 32'hFFFF0000;
  localparam logic [7:0]  LL6_B0    = 8'hFE;
  localparam logic [7:0]  LL6_B1    = 8'h80;
  localparam logic [7:0]  LL6_MASK  = 8'hC0;
  localparam logic [7:0]  ULA_B0    = 8'hFC;
  localparam logic [7:0]  ULA_MASK  = 8'hFE;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_SEMI) || (c == CH_COMMA);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Nibble value of a hex digit; letters have bit 6 set.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] r;
    if (c[6]) begin
      r = c[3:0] + 4'd9;
    end else begin
      r = c[3:0];
    end
    return r;
  endfunction

  // Letter of the key word "for" at a given position.
  function automatic logic [7:0] for_letter(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h66;
      3'd1:    r = 8'h6F;
      default: r = 8'h72;
    endcase
    return r;
  endfunction

  // Byte of an IPv4 word, first octet at offset zero.
  function automatic logic [7:0] v4_byte(input logic [31:0] a, input logic [1:0] off);
    logic [7:0] r;
    case (off)
      2'd0:    r = a[31:24];
      2'd1:    r = a[23:16];
      2'd2:    r = a[15:8];
      default: r = a[7:0];
    endcase
    return r;
  endfunction

  // One character step of a dotted IPv4 parse.
  function automatic v4_t v4_step(input v4_t s, input logic [7:0] c);
    v4_t         r;
    logic [11:0] nv;
    r  = s;
    nv = ({4'd0, s.val} << 3) + ({4'd0, s.val} << 1) + {8'd0, c[3:0]};
    if (!s.fail) begin
      if (is_digit(c)) begin
        if ((s.saw && (s.val == 8'd0)) || (nv > 12'd255)) begin
          r.fail = 1'b1;
        end else if (!s.saw && (s.octets == 3'd4)) begin
          r.fail = 1'b1;
        end else begin
          r.val = nv[7:0];
          if (!s.saw) begin
            r.octets = s.octets + 3'd1;
            r.saw    = 1'b1;
          end
          case (r.octets)
            3'd1:    r.addr[31:24] = nv[7:0];
            3'd2:    r.addr[23:16] = nv[7:0];
            3'd3:    r.addr[15:8]  = nv[7:0];
            default: r.addr[7:0]   = nv[7:0];
          endcase
        end
      end else if ((c == CH_DOT) && s.saw) begin
        if (s.octets == 3'd4) begin
          r.fail = 1'b1;
        end else begin
          r.val = 8'd0;
          r.saw = 1'b0;
        end
      end else begin
        r.fail = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic private_v4(input logic [31:0] a);
    return ((a & MASK_8) == NET_10) || ((a & MASK_12) == NET_172) ||
           ((a & MASK_16) == NET_192) || ((a & MASK_8) == NET_LOOP) ||
           ((a & MASK_16) == NET_LINK);
  endfunction

endpackage

>>> rtl/core/fhc_if.sv
// Stream interfaces for the forwarded header client address parser.
// Input carries header characters, output carries the result item.
// No dependencies.
interface fhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface fhc_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        is_v6;
  logic [63:0] address_high;
  logic [63:0] address_low;
  modport source (output valid, output found, output is_v6, output address_high,
                  output address_low, input ready);
  modport sink (input valid, input found, input is_v6, input address_high,
                input address_low, output ready);
endinterface

>>> rtl/core/forwarded_header_client_ip_parser_unit.sv
// Forwarded header client address parser, top level.
// Uses fhc_pkg, the stream interfaces in fhc_if.sv and the fhc_ram buffer.
//
// Header characters are taken one per cycle while no captured value is being
// evaluated. When a for= value ends, its text (at most TEXT_MAX characters)
// is walked out of the fhc_ram text buffer, a fetch and a step state per
// character, by one character parser that runs the IPv4 and IPv6 rules side
// by side. A last fetch and a finish state close the text, the expand state
// opens the IPv6 zero gap one byte a cycle, and a check state classifies
// the address.
// The item marked last yields one result item; no input is taken while the
// result waits, and once it is taken the parser is back in its reset state.
module forwarded_header_client_ip_parser_unit #(
  parameter int TEXT_MAX = 46
) (
  input logic clk,
  input logic rst,
  fhc_in_if.sink    in_ch,
  fhc_out_if.source out_ch
);

  localparam int AW = $clog2(TEXT_MAX);
  localparam int LW = $clog2(TEXT_MAX + 1);

  fhc_pkg::ctrl_t  state, state_next;
  fhc_pkg::scan_t  scan, scan_n;
  fhc_pkg::phase_t phase, ph_n;

  logic          key_is_for, kif_n;
  logic [2:0]    key_length, klen_n;
  logic          escape, esc_n;
  logic [LW-1:0] text_length, len_n;
  logic          overflow, ovf_n;
  logic          found_flag, found_v6;
  logic [63:0]   found_hi, found_lo;

  logic          do_cap, eval_req, eval_go, store_we;
  logic [AW-1:0] store_addr;
  logic [7:0]    c;
  logic          in_fire, out_fire;

  // Parse datapath registers.
  logic [LW-1:0] idx;
  logic          pend_last;
  fhc_pkg::v4_t  v4m, v4s;
  logic          v6_fail, lead, colon_last, tail, gap_vld;
  logic [4:0]    tp, gap;
  logic [2:0]    xd;
  logic [15:0]   hval;
  logic [7:0]    v6b [16];
  logic [7:0]    ch;

  logic          fin_fail, put_tail, put_grp;
  logic [4:0]    tp_fin;

  logic          cand_ok, cand_v6;
  logic [63:0]   cand_hi, cand_lo;

  assign c        = in_ch.byte_value;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // Header scanner: next values for one character.
  always_comb begin
    fhc_pkg::phase_t ph_c;
    scan_n     = scan;
    kif_n      = key_is_for;
    klen_n     = key_length;
    esc_n      = escape;
    len_n      = text_length;
    ph_n       = phase;
    ovf_n      = overflow;
    do_cap     = 1'b0;
    eval_req   = 1'b0;
    store_we   = 1'b0;
    store_addr = text_length[AW-1:0];
    ph_c       = phase;
    unique case (scan)
      fhc_pkg::SC_KEY: begin
        if (c == fhc_pkg::CH_EQUAL) begin
          kif_n  = key_is_for && (key_length == 3'd3);
          scan_n = fhc_pkg::SC_BEFORE;
        end else begin
          if ((key_length < 3'd3) &&
              ((c | fhc_pkg::CH_LOWER) != fhc_pkg::for_letter(key_length))) begin
            kif_n = 1'b0;
          end
          if (key_length < 3'd4) begin
            klen_n = key_length + 3'd1;
          end
        end
      end
      fhc_pkg::SC_BEFORE: begin
        ph_n  = fhc_pkg::PH_NONE;
        len_n = '0;
        ovf_n = 1'b0;
        esc_n = 1'b0;
        if (c == fhc_pkg::CH_QUOTE) begin
          scan_n = fhc_pkg::SC_QUOTED;
        end else if (fhc_pkg::is_sep(c)) begin
          scan_n = fhc_pkg::SC_BETWEEN;
        end else begin
          do_cap = 1'b1;
          scan_n = fhc_pkg::SC_TOKEN;
        end
      end
      fhc_pkg::SC_TOKEN: begin
        if (fhc_pkg::is_sep(c) || in_ch.last_byte) begin
          do_cap   = !fhc_pkg::is_sep(c);
          eval_req = 1'b1;
          scan_n   = fhc_pkg::SC_BETWEEN;
        end else begin
          do_cap = 1'b1;
        end
      end
      fhc_pkg::SC_QUOTED: begin
        if (escape) begin
          do_cap = 1'b1;
          esc_n  = 1'b0;
        end else if (c == fhc_pkg::CH_QUOTE) begin
          eval_req = 1'b1;
          scan_n   = fhc_pkg::SC_BETWEEN;
        end else begin
          do_cap = 1'b1;
          esc_n  = (c == fhc_pkg::CH_BSLASH);
        end
      end
      default: begin
        if (!fhc_pkg::is_sep(c)) begin
          klen_n = 3'd1;
          kif_n  = ((c | fhc_pkg::CH_LOWER) == fhc_pkg::for_letter(3'd0));
          scan_n = fhc_pkg::SC_KEY;
        end
      end
    endcase

    // Value capture: bracketed text up to ']', plain text up to ':'.
    if (do_cap) begin
      ph_c = ph_n;
      if (ph_c == fhc_pkg::PH_NONE) begin
        if (c == fhc_pkg::CH_LBRACK) begin
          ph_n = fhc_pkg::PH_BRACKET;
          ph_c = fhc_pkg::PH_DONE;
        end else begin
          ph_c = fhc_pkg::PH_PLAIN;
          ph_n = fhc_pkg::PH_PLAIN;
        end
      end
      if (((ph_c == fhc_pkg::PH_PLAIN) && (c == fhc_pkg::CH_COLON)) ||
          ((ph_c == fhc_pkg::PH_BRACKET) && (c == fhc_pkg::CH_RBRACK))) begin
        ph_n = fhc_pkg::PH_DONE;
      end else if ((ph_c == fhc_pkg::PH_PLAIN) || (ph_c == fhc_pkg::PH_BRACKET)) begin
        if (len_n < LW'(TEXT_MAX)) begin
          store_we   = 1'b1;
          store_addr = len_n[AW-1:0];
          len_n      = len_n + 1'b1;
        end else begin
          ovf_n = 1'b1;
        end
      end
    end
  end

  assign eval_go = eval_req && key_is_for && !ovf_n && (len_n != '0) &&
                   ((ph_n == fhc_pkg::PH_PLAIN) || (ph_n == fhc_pkg::PH_DONE));

  fhc_ram #(
    .WIDTH (8),
    .DEPTH (TEXT_MAX)
  ) u_text (
    .clk   (clk),
    .we    (in_fire && !found_flag && store_we),
    .waddr (store_addr),
    .wdata (c),
    .raddr (idx[AW-1:0]),
    .rdata (ch)
  );

  // End of text: flush the last group or the IPv4 tail.
  always_comb begin
    fin_fail = v6_fail;
    put_tail = 1'b0;
    put_grp  = 1'b0;
    tp_fin   = tp;
    if ((idx == '0) || (lead && (idx == LW'(1))) || colon_last) begin
      fin_fail = 1'b1;
    end
    if (tail) begin
      if (v4s.fail || (v4s.octets != 3'd4)) begin
        fin_fail = 1'b1;
      end else begin
        put_tail = 1'b1;
        tp_fin   = tp + 5'd4;
      end
    end else if (xd != 3'd0) begin
      if (tp > 5'd14) begin
        fin_fail = 1'b1;
      end else begin
        put_grp = 1'b1;
        tp_fin  = tp + 5'd2;
      end
    end
    if (gap_vld && (tp_fin == 5'd16)) begin
      fin_fail = 1'b1;
    end
  end

  // Address classification.
  always_comb begin
    logic [31:0] a;
    logic        mapped, zero10, loop6;
    cand_ok = 1'b0;
    cand_v6 = 1'b0;
    cand_hi = '0;
    cand_lo = '0;
    zero10  = 1'b1;
    loop6   = 1'b1;
    for (int k = 0; k < 10; k++) begin
      if (v6b[k] != 8'd0) zero10 = 1'b0;
    end
    for (int k = 0; k < 15; k++) begin
      if (v6b[k] != 8'd0) loop6 = 1'b0;
    end
    loop6 = loop6 && (v6b[15] == 8'd1);
    if (!v4m.fail && (v4m.octets == 3'd4)) begin
      mapped = 1'b1;
      a      = v4m.addr;
    end else begin
      mapped = zero10 && (v6b[10] == 8'hFF) && (v6b[11] == 8'hFF);
      a      = {v6b[12], v6b[13], v6b[14], v6b[15]};
    end
    if (!v4m.fail && (v4m.octets == 3'd4)) begin
      cand_ok = !fhc_pkg::private_v4(a);
      cand_lo = {32'd0, a};
    end else if (!v6_fail && (tp == 5'd16)) begin
      if (mapped) begin
        cand_ok = !fhc_pkg::private_v4(a);
        cand_lo = {32'd0, a};
      end else begin
        cand_ok = !(loop6 ||
                    ((v6b[0] == fhc_pkg::LL6_B0) &&
                     ((v6b[1] & fhc_pkg::LL6_MASK) == fhc_pkg::LL6_B1)) ||
                    ((v6b[0] & fhc_pkg::ULA_MASK) == fhc_pkg::ULA_B0));
        cand_v6 = 1'b1;
        cand_hi = {v6b[0], v6b[1], v6b[2], v6b[3], v6b[4], v6b[5], v6b[6], v6b[7]};
        cand_lo = {v6b[8], v6b[9], v6b[10], v6b[11], v6b[12], v6b[13], v6b[14], v6b[15]};
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fhc_pkg::C_IDLE: begin
        if (in_fire) begin
          if (!found_flag && eval_go) begin
            state_next = fhc_pkg::C_FETCH;
          end else if (in_ch.last_byte) begin
            state_next = fhc_pkg::C_OUT;
          end
        end
      end
      fhc_pkg::C_FETCH: begin
        state_next = (idx == text_length) ? fhc_pkg::C_FINISH : fhc_pkg::C_STEP;
      end
      fhc_pkg::C_STEP: begin
        state_next = (ch == 8'd0) ? fhc_pkg::C_FINISH : fhc_pkg::C_FETCH;
      end
      fhc_pkg::C_FINISH: begin
        state_next = (!fin_fail && gap_vld) ? fhc_pkg::C_EXPAND : fhc_pkg::C_CHECK;
      end
      fhc_pkg::C_EXPAND: begin
        if (tp == 5'd16) state_next = fhc_pkg::C_CHECK;
      end
      fhc_pkg::C_CHECK: begin
        state_next = pend_last ? fhc_pkg::C_OUT : fhc_pkg::C_IDLE;
      end
      fhc_pkg::C_OUT: begin
        if (out_fire) state_next = fhc_pkg::C_IDLE;
      end
      default: state_next = fhc_pkg::C_IDLE;
    endcase
  end

  // Handshake and result outputs.
  always_comb begin
    in_ch.ready         = (state == fhc_pkg::C_IDLE);
    out_ch.valid        = (state == fhc_pkg::C_OUT);
    out_ch.found        = found_flag;
    out_ch.is_v6        = found_flag && found_v6;
    out_ch.address_high = found_flag ? found_hi : 64'd0;
    out_ch.address_low  = found_flag ? found_lo : 64'd0;
  end

  // Control and scanner registers.
  always_ff @(posedge clk) begin
    if (rst || out_fire) begin
      state       <= fhc_pkg::C_IDLE;
      scan        <= fhc_pkg::SC_BETWEEN;
      phase       <= fhc_pkg::PH_NONE;
      key_is_for  <= 1'b0;
      key_length  <= 3'd0;
      escape      <= 1'b0;
      text_length <= '0;
      overflow    <= 1'b0;
      found_flag  <= 1'b0;
      found_v6    <= 1'b0;
      found_hi    <= '0;
      found_lo    <= '0;
    end else begin
      state <= state_next;
      if (in_fire && !found_flag) begin
        scan        <= scan_n;
        phase       <= ph_n;
        key_is_for  <= kif_n;
        key_length  <= klen_n;
        escape      <= esc_n;
        text_length <= len_n;
        overflow    <= ovf_n;
      end
      if ((state == fhc_pkg::C_CHECK) && cand_ok) begin
        found_flag <= 1'b1;
        found_v6   <= cand_v6;
        found_hi   <= cand_hi;
        found_lo   <= cand_lo;
      end
    end
  end

  // Parse datapath: one text character per step.
  always_ff @(posedge clk) begin
    unique case (state)
      fhc_pkg::C_IDLE: begin
        idx        <= '0;
        pend_last  <= in_ch.last_byte;
        v4m        <= fhc_pkg::V4_INIT;
        v4s        <= fhc_pkg::V4_INIT;
        v6_fail    <= 1'b0;
        lead       <= 1'b0;
        colon_last <= 1'b0;
        tail       <= 1'b0;
        gap_vld    <= 1'b0;
        gap        <= 5'd0;
        tp         <= 5'd0;
        xd         <= 3'd0;
        hval       <= 16'd0;
        for (int k = 0; k < 16; k++) v6b[k] <= 8'd0;
      end
      fhc_pkg::C_STEP: begin
        if (ch != 8'd0) begin
          idx <= idx + 1'b1;
          v4m <= fhc_pkg::v4_step(v4m, ch);
          if (!tail && (ch == fhc_pkg::CH_COLON)) begin
            v4s <= fhc_pkg::V4_INIT;
          end else begin
            v4s <= fhc_pkg::v4_step(v4s, ch);
          end
          if (!v6_fail && !tail) begin
            colon_last <= 1'b0;
            if ((idx == '0) && (ch == fhc_pkg::CH_COLON)) begin
              lead <= 1'b1;
            end else if ((idx == LW'(1)) && lead && (ch != fhc_pkg::CH_COLON)) begin
              v6_fail <= 1'b1;
            end else if (fhc_pkg::is_hex(ch)) begin
              if (xd == 3'd4) begin
                v6_fail <= 1'b1;
              end else begin
                hval <= {hval[11:0], fhc_pkg::hex_val(ch)};
                xd   <= xd + 3'd1;
              end
            end else if (ch == fhc_pkg::CH_COLON) begin
              if (xd == 3'd0) begin
                if (gap_vld) begin
                  v6_fail <= 1'b1;
                end else begin
                  gap_vld <= 1'b1;
                  gap     <= tp;
                end
              end else if (tp > 5'd14) begin
                v6_fail <= 1'b1;
              end else begin
                v6b[tp[3:0]]        <= hval[15:8];
                v6b[tp[3:0] + 4'd1] <= hval[7:0];
                tp         <= tp + 5'd2;
                xd         <= 3'd0;
                hval       <= 16'd0;
                colon_last <= 1'b1;
              end
            end else if (ch == fhc_pkg::CH_DOT) begin
              if (tp <= 5'd12) begin
                tail <= 1'b1;
              end else begin
                v6_fail <= 1'b1;
              end
            end else begin
              v6_fail <= 1'b1;
            end
          end
        end
      end
      fhc_pkg::C_FINISH: begin
        v6_fail <= fin_fail;
        tp      <= tp_fin;
        for (int k = 0; k < 16; k++) begin
          if (put_tail && (5'(k) >= tp) && (5'(k) < tp + 5'd4)) begin
            v6b[k] <= fhc_pkg::v4_byte(v4s.addr, 2'(5'(k) - tp));
          end
          if (put_grp && (5'(k) == tp)) v6b[k] <= hval[15:8];
          if (put_grp && (5'(k) == tp + 5'd1)) v6b[k] <= hval[7:0];
        end
      end
      fhc_pkg::C_EXPAND: begin
        // Insert one zero byte at the gap and move the tail up.
        if (tp != 5'd16) begin
          tp <= tp + 5'd1;
          for (int k = 0; k < 16; k++) begin
            if (5'(k) == gap) begin
              v6b[k] <= 8'd0;
            end else if ((5'(k) > gap) && (k > 0)) begin
              v6b[k] <= v6b[k-1];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/fhc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 46
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> dv/fhc_checker.sv
`timescale 1ns / 1ps
// Result checker for the forwarded header client address parser.
// Watches both stream interfaces from fhc_if.sv and uses fhc_pkg types.
module fhc_checker (
  input  logic clk,
  input  logic rst,
  fhc_in_if    in_ch,
  fhc_out_if   out_ch,
  output int   errors,
  output int   pending,
  output int   results
);

  localparam int TEXT_MAX = 46;

  typedef struct {
    bit        found;
    bit        is_v6;
    bit [63:0] address_high;
    bit [63:0] address_low;
  } verdict_t;

  verdict_t verdict_q[$];

  // Shadow copy of the scanner and capture state.
  fhc_pkg::scan_t  sc;
  fhc_pkg::phase_t ph;
  bit        key_for;
  bit [2:0]  key_len;
  bit        esc;
  bit [7:0]  text[TEXT_MAX];
  int        text_len;
  bit        ovf;
  bit        got;
  bit        got_v6;
  bit [63:0] got_hi;
  bit [63:0] got_lo;

  function automatic void clear_scan();
    sc = fhc_pkg::SC_BETWEEN;
    key_for = 0;
    key_len = 0;
    ph = fhc_pkg::PH_NONE;
    text_len = 0;
    ovf = 0;
    esc = 0;
    got = 0;
    got_v6 = 0;
    got_hi = 0;
    got_lo = 0;
  endfunction

  function automatic int hex_digit(bit [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // Dotted quad with no leading zeros, four octets exactly.
  function automatic bit dotted_quad(int s, int n, output bit [31:0] a);
    int oct, val, nv;
    bit saw;
    oct = 0;
    val = 0;
    saw = 0;
    a = 0;
    for (int i = s; i < s + n; i++) begin
      if (text[i] >= "0" && text[i] <= "9") begin
        nv = val * 10 + (text[i] - "0");
        if (saw && val == 0) return 0;
        if (nv > 255) return 0;
        val = nv;
        if (!saw) begin
          oct++;
          if (oct > 4) return 0;
          saw = 1;
        end
        a[31 - 8 * (oct - 1) -: 8] = val[7:0];
      end else if (text[i] == "." && saw) begin
        if (oct == 4) return 0;
        val = 0;
        saw = 0;
      end else begin
        return 0;
      end
    end
    return oct == 4;
  endfunction

  // Colon hex form with one optional zero gap and an optional dotted tail.
  function automatic bit colon_hex(int n, output bit [127:0] r);
    bit [7:0]  t[16];
    bit [31:0] a4;
    int tp, i, xd, gap, cur, d, moved;
    bit [15:0] val;
    bit [7:0] ch;
    r = 0;
    for (int k = 0; k < 16; k++) t[k] = 0;
    tp = 0; i = 0; xd = 0; gap = -1; val = 0;
    if (n == 0) return 0;
    if (text[0] == ":") begin
      i = 1;
      if (i == n || text[i] != ":") return 0;
    end
    cur = i;
    while (i < n) begin
      ch = text[i];
      i++;
      d = hex_digit(ch);
      if (d >= 0) begin
        if (xd == 4) return 0;
        val = (val << 4) | d[15:0];
        xd++;
      end else if (ch == ":") begin
        cur = i;
        if (xd == 0) begin
          if (gap >= 0) return 0;
          gap = tp;
        end else begin
          if (i == n) return 0;
          if (tp + 2 > 16) return 0;
          t[tp] = val[15:8];
          t[tp + 1] = val[7:0];
          tp += 2;
          xd = 0;
          val = 0;
        end
      end else if (ch == "." && tp + 4 <= 16 && dotted_quad(cur, n - cur, a4)) begin
        for (int k = 0; k < 4; k++) t[tp + k] = a4[31 - 8 * k -: 8];
        tp += 4;
        xd = 0;
        break;
      end else begin
        return 0;
      end
    end
    if (xd > 0) begin
      if (tp + 2 > 16) return 0;
      t[tp] = val[15:8];
      t[tp + 1] = val[7:0];
      tp += 2;
    end
    if (gap >= 0) begin
      if (tp == 16) return 0;
      moved = tp - gap;
      for (int k = moved - 1; k >= 0; k--) t[16 - moved + k] = t[gap + k];
      for (int k = gap; k < 16 - moved; k++) t[k] = 0;
      tp = 16;
    end
    if (tp != 16) return 0;
    for (int k = 0; k < 16; k++) r[127 - 8 * k -: 8] = t[k];
    return 1;
  endfunction

  // Parse the captured text and keep it when it is a public address.
  function automatic void judge_text();
    bit [127:0] b;
    bit [31:0]  a;
    int len;
    bit mapped;
    if (ph == fhc_pkg::PH_NONE || ph == fhc_pkg::PH_BRACKET || ovf) return;
    len = 0;
    while (len < text_len && len < TEXT_MAX && text[len] != 0) len++;
    if (len == 0) return;
    if (dotted_quad(0, len, a)) begin
      mapped = 1;
      b = {96'd0, a};
    end else begin
      if (!colon_hex(len, b)) return;
      mapped = (b[127:48] == 80'd0) && (b[47:32] == 16'hFFFF);
    end
    if (mapped) begin
      a = b[31:0];
      if ((a & fhc_pkg::MASK_8) == fhc_pkg::NET_10 ||
          (a & fhc_pkg::MASK_12) == fhc_pkg::NET_172 ||
          (a & fhc_pkg::MASK_16) == fhc_pkg::NET_192 ||
          (a & fhc_pkg::MASK_8) == fhc_pkg::NET_LOOP ||
          (a & fhc_pkg::MASK_16) == fhc_pkg::NET_LINK) return;
      got_v6 = 0;
      got_hi = 0;
      got_lo = {32'd0, a};
    end else begin
      if (b == 128'd1) return;
      if (b[127:120] == fhc_pkg::LL6_B0 &&
          (b[119:112] & fhc_pkg::LL6_MASK) == fhc_pkg::LL6_B1) return;
      if ((b[127:120] & fhc_pkg::ULA_MASK) == fhc_pkg::ULA_B0) return;
      got_v6 = 1;
      got_hi = b[127:64];
      got_lo = b[63:0];
    end
    got = 1;
  endfunction

  function automatic void keep_char(bit [7:0] c);
    if (text_len < TEXT_MAX) begin
      text[text_len] = c;
      text_len++;
    end else begin
      ovf = 1;
    end
  endfunction

  function automatic void capture_char(bit [7:0] c);
    if (ph == fhc_pkg::PH_NONE) begin
      if (c == fhc_pkg::CH_LBRACK) begin
        ph = fhc_pkg::PH_BRACKET;
        return;
      end
      ph = fhc_pkg::PH_PLAIN;
    end
    if (ph == fhc_pkg::PH_PLAIN) begin
      if (c == fhc_pkg::CH_COLON) ph = fhc_pkg::PH_DONE;
      else keep_char(c);
    end else if (ph == fhc_pkg::PH_BRACKET) begin
      if (c == fhc_pkg::CH_RBRACK) ph = fhc_pkg::PH_DONE;
      else keep_char(c);
    end
  endfunction

  function automatic bit sep_char(bit [7:0] c);
    return c == fhc_pkg::CH_SPACE || c == fhc_pkg::CH_SEMI || c == fhc_pkg::CH_COMMA;
  endfunction

  // Advance the shadow scanner by one header character.
  function automatic void scan_char(bit [7:0] c, bit last);
    bit [7:0] fw[3];
    verdict_t v;
    fw[0] = "f"; fw[1] = "o"; fw[2] = "r";
    if (!got) begin
      case (sc)
        fhc_pkg::SC_KEY: begin
          if (c == fhc_pkg::CH_EQUAL) begin
            key_for = key_for && key_len == 3;
            sc = fhc_pkg::SC_BEFORE;
          end else begin
            if (key_len < 3 && (c | fhc_pkg::CH_LOWER) != fw[key_len]) key_for = 0;
            if (key_len < 4) key_len++;
          end
        end
        fhc_pkg::SC_BEFORE: begin
          ph = fhc_pkg::PH_NONE;
          text_len = 0;
          ovf = 0;
          esc = 0;
          if (c == fhc_pkg::CH_QUOTE) sc = fhc_pkg::SC_QUOTED;
          else if (sep_char(c)) sc = fhc_pkg::SC_BETWEEN;
          else begin
            capture_char(c);
            sc = fhc_pkg::SC_TOKEN;
          end
        end
        fhc_pkg::SC_TOKEN: begin
          if (sep_char(c) || last) begin
            if (!sep_char(c)) capture_char(c);
            if (key_for) judge_text();
            sc = fhc_pkg::SC_BETWEEN;
          end else begin
            capture_char(c);
          end
        end
        fhc_pkg::SC_QUOTED: begin
          if (esc) begin
            capture_char(c);
            esc = 0;
          end else if (c == fhc_pkg::CH_QUOTE) begin
            if (key_for) judge_text();
            sc = fhc_pkg::SC_BETWEEN;
          end else begin
            capture_char(c);
            if (c == fhc_pkg::CH_BSLASH) esc = 1;
          end
        end
        default: begin
          if (!sep_char(c)) begin
            key_len = 1;
            key_for = (c | fhc_pkg::CH_LOWER) == "f";
            sc = fhc_pkg::SC_KEY;
          end else begin
            sc = fhc_pkg::SC_BETWEEN;
          end
        end
      endcase
    end
    if (last) begin
      v.found = got;
      v.is_v6 = got && got_v6;
      v.address_high = got ? got_hi : 64'd0;
      v.address_low = got ? got_lo : 64'd0;
      verdict_q.push_back(v);
      clear_scan();
    end
  endfunction

  // Sample both channels at the rising edge; inputs first, then results.
  always @(posedge clk) begin
    verdict_t w;
    if (rst) begin
      clear_scan();
      verdict_q.delete();
      errors <= 0;
      results <= 0;
      pending <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) scan_char(in_ch.byte_value, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        results <= results + 1;
        if (verdict_q.size() == 0) begin
          $error("result item arrived with none expected");
          errors <= errors + 1;
        end else begin
          w = verdict_q.pop_front();
          if (out_ch.found !== w.found || out_ch.is_v6 !== w.is_v6 ||
              out_ch.address_high !== w.address_high ||
              out_ch.address_low !== w.address_low) begin
            errors <= errors + 1;
            if (out_ch.found !== w.found)
              $error("found: expected %0h, got %0h", w.found, out_ch.found);
            if (out_ch.is_v6 !== w.is_v6)
              $error("is_v6: expected %0h, got %0h", w.is_v6, out_ch.is_v6);
            if (out_ch.address_high !== w.address_high)
              $error("address_high: expected %h, got %h", w.address_high,
                     out_ch.address_high);
            if (out_ch.address_low !== w.address_low)
              $error("address_low: expected %h, got %h", w.address_low,
                     out_ch.address_low);
          end
        end
      end
      pending <= verdict_q.size();
    end
  end

endmodule

>>> dv/forwarded_header_client_ip_parser_unit_test.sv
`timescale 1ns / 1ps
// Top of the forwarded header client address parser testbench.
// Drives header values into the unit and relies on fhc_checker for results.
module forwarded_header_client_ip_parser_unit_test;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int BYTE_GOAL = 1900;
  localparam int HOLD_LEN = 600;

  logic clk;
  logic rst;
  int   errors, pending, results;
  int   cycles = 0;
  int   send_idle_pct, stall_pct;
  bit   hold_req;
  int   bytes_sent, headers_sent;
  byte unsigned hdr[$];

  fhc_in_if  in_ch ();
  fhc_out_if out_ch ();

  forwarded_header_client_ip_parser_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  fhc_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .errors(errors), .pending(pending), .results(results)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Run-time guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("forwarded_header_client_ip_parser_unit_test failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one header character and wait until it is taken.
  task automatic put_char(input byte unsigned c, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 0;
    end
    @(negedge clk);
    in_ch.valid <= 1;
    in_ch.byte_value <= c;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_header();
    for (int i = 0; i < hdr.size(); i++) put_char(hdr[i], i == hdr.size() - 1);
    headers_sent++;
    hdr.delete();
  endtask

  task automatic add(input string s);
    for (int i = 0; i < s.len(); i++) hdr.push_back(s[i]);
  endtask

  function automatic string quad();
    int f, s;
    case ($urandom_range(7))
      0: f = 10;
      1: f = 127;
      2: f = 172;
      3: f = 192;
      4: f = 169;
      default: f = $urandom_range(1, 223);
    endcase
    s = $urandom_range(255);
    if (f == 172 && $urandom_range(1)) s = $urandom_range(16, 31);
    if (f == 192 && $urandom_range(1)) s = 168;
    if (f == 169 && $urandom_range(1)) s = 254;
    if ($urandom_range(15) == 0)
      return $sformatf("%0d.0%0d.%0d.%0d", f, s, $urandom_range(9), $urandom_range(300));
    return $sformatf("%0d.%0d.%0d.%0d", f, s, $urandom_range(255), $urandom_range(255));
  endfunction

  // IPv6 text with a random prefix, group count and zero gap.
  function automatic string hex_text();
    string s, g;
    int k, gp;
    case ($urandom_range(9))
      0: return "::1";
      1: return {"::ffff:", quad()};
      2: return {"::", quad()};
      default: ;
    endcase
    k = $urandom_range(1, 8);
    gp = ($urandom_range(2) == 0 || k == 8) ? -1 : $urandom_range(k);
    s = "";
    for (int i = 0; i < k; i++) begin
      if (i == gp) s = {s, "::"};
      else if (i > 0) s = {s, ":"};
      case ($urandom_range(5))
        0: g = "fe80";
        1: g = "fd12";
        2: g = "2001";
        3: g = "FC0A";
        default: g = $sformatf("%0h", $urandom_range(65535));
      endcase
      s = {s, g};
    end
    if (gp == k) s = {s, "::"};
    if ($urandom_range(9) == 0) s = {s, "%eth0"};
    return s;
  endfunction

  // One key=value pair, mostly for= with a plausible address.
  task automatic add_pair();
    string keys[8];
    int    n;
    keys = '{"for", "For", "FOR", "fOr", "by", "proto", "fo", "forx"};
    add(keys[$urandom_range(3) == 0 ? $urandom_range(7) : $urandom_range(3)]);
    add("=");
    case ($urandom_range(9))
      0: add(quad());
      1: add({quad(), ":", $sformatf("%0d", $urandom_range(65535))});
      2: add({"\"[", hex_text(), "]:", $sformatf("%0d", $urandom_range(9999)), "\""});
      3: add({"\"", hex_text(), "\""});
      4: add({"[", hex_text(), "]"});
      5: add({"\"[", hex_text()});
      6: add({"\"", quad(), "\\", "\\\""});
      7: add({"\"", hex_text(), hex_text(), hex_text(), "\""});
      8: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) hdr.push_back(8'($urandom_range(255)));
      end
      default: add(hex_text());
    endcase
  endtask

  task automatic random_header();
    int n;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) hdr.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0) add(" ");
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) add($urandom_range(1) ? ";" : ", ");
        add_pair();
      end
      if ($urandom_range(5) == 0) add(";");
    end
    send_header();
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.byte_value = 0;
    in_ch.last_byte = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    bytes_sent = 0;
    headers_sent = 0;
    rst = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: public v4 at the last byte, mapped v6, private v4 with zero byte, escapes.
    add("for=8.8.8.8");
    send_header();
    add("FOR=\"[::ffff:1.2.3.4]:80\"");
    send_header();
    hdr.push_back("x");
    add(";for=10.1.1.1");
    hdr.push_back(8'd0);
    send_header();
    add("for=\"2\\a::1\",for=");
    send_header();
    drain();

    // Random phases with different idle mixes.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        3: begin send_idle_pct = 28; stall_pct = 28; end
        default: begin send_idle_pct = 0; stall_pct = 10; end
      endcase
      if (phase == 4) hold_req = 1;
      while (bytes_sent < (phase + 1) * BYTE_GOAL / 5) random_header();
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Sent %0d header bytes in %0d header values; %0d result items checked.",
             bytes_sent, headers_sent, results);
    if (errors == 0 && pending == 0) begin
      $display("forwarded_header_client_ip_parser_unit_test passed");
    end else begin
      $display("forwarded_header_client_ip_parser_unit_test failed");
    end
    $finish;
  end

endmodule
